FILE: hw/rtl/timer_wakeup_priority_queue_unit_macros.svh
// Assertion macros used by the timer wakeup queue chain RTL.
`ifndef TIMER_WAKEUP_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define TIMER_WAKEUP_PRIORITY_QUEUE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define TWPQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("twpq: implication check failed");
`define TWPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("twpq: next-cycle check failed");
`else
`define TWPQ_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define TWPQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hw/rtl/twpq_pkg.sv
// Types, constants and key compare for the timer wakeup queue.
`timescale 1ns / 1ps
package twpq_pkg;

   localparam int QUEUE_DEPTH_DEF = 64;
   localparam int HANDLE_W        = 16;
   localparam int TIME_W          = 63;

   localparam logic [1:0] MODE_ENQ  = 2'd0;
   localparam logic [1:0] MODE_TICK = 2'd1;
   localparam logic [1:0] MODE_PEEK = 2'd2;

   typedef struct packed {
      logic [1:0]          mode;
      logic [HANDLE_W-1:0] handle_id;
      logic [TIME_W-1:0]   time_value;
   } req_type;

   typedef struct packed {
      logic                has_entry;
      logic [HANDLE_W-1:0] out_handle;
      logic [TIME_W-1:0]   out_wake_time;
      logic                last_of_run;
      logic                overflow;
   } rsp_type;

   typedef struct packed {
      logic                valid;
      logic [TIME_W-1:0]   wake_time;
      logic [HANDLE_W-1:0] handle;
   } entry_type;

   typedef struct packed {
      logic insert;
      logic shift;
   } cmd_type;

   typedef struct packed {
      entry_type head;
      entry_type second;
      logic      full;
   } status_type;

   function automatic logic key_less(input entry_type a, input entry_type b);
      key_less = (a.wake_time < b.wake_time) ||
                 ((a.wake_time == b.wake_time) && (a.handle < b.handle));
   endfunction

endpackage

FILE: hw/rtl/twpq_cell.sv
// One slot of the sorted chain: holds an entry, shifts or inserts.
`timescale 1ns / 1ps
module twpq_cell (
   input  logic                clock,
   input  logic                reset,
   input  twpq_pkg::cmd_type   cmd,
   input  twpq_pkg::entry_type key_in,
   input  twpq_pkg::entry_type left_in,
   input  logic                left_lt,
   input  twpq_pkg::entry_type right_in,
   output twpq_pkg::entry_type own_out,
   output logic                key_lt
);
   import twpq_pkg::*;

   logic                valid_ff, valid_in;
   logic [TIME_W-1:0]   time_ff, time_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   entry_type           own;
   entry_type           pick;

   assign own.valid     = valid_ff;
   assign own.wake_time = time_ff;
   assign own.handle    = handle_ff;
   assign own_out       = own;

   assign key_lt = !valid_ff || key_less(key_in, own);

   always_comb begin
      pick = own;
      priority if (cmd.shift) begin
         pick = right_in;
      end else if (cmd.insert && key_lt) begin
         pick = left_lt ? left_in : key_in;
      end else begin
         pick = own;
      end
      valid_in  = pick.valid;
      time_in   = pick.wake_time;
      handle_in = pick.handle;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      time_ff   <= time_in;
      handle_ff <= handle_in;
   end

endmodule

FILE: hw/rtl/twpq_chain.sv
// Row of cells kept sorted by wake time, then handle; head is earliest.
`timescale 1ns / 1ps
`include "timer_wakeup_priority_queue_unit_macros.svh"
module twpq_chain #(
   parameter int QUEUE_DEPTH = twpq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  twpq_pkg::cmd_type    cmd,
   input  twpq_pkg::entry_type  key_in,
   output twpq_pkg::status_type status
);
   import twpq_pkg::*;

   entry_type ent      [QUEUE_DEPTH];
   entry_type left_ent [QUEUE_DEPTH];
   entry_type right_ent[QUEUE_DEPTH];
   logic      lt       [QUEUE_DEPTH];
   logic      left_lt  [QUEUE_DEPTH];

   genvar gi;
   generate
      for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
         if (gi == 0) begin : g_first
            assign left_ent[gi] = '0;
            assign left_lt[gi]  = 1'b0;
         end else begin : g_mid
            assign left_ent[gi] = ent[gi-1];
            assign left_lt[gi]  = lt[gi-1];
         end
         if (gi == QUEUE_DEPTH - 1) begin : g_last
            assign right_ent[gi] = '0;
         end else begin : g_inner
            assign right_ent[gi] = ent[gi+1];
         end
         twpq_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .cmd      (cmd),
            .key_in   (key_in),
            .left_in  (left_ent[gi]),
            .left_lt  (left_lt[gi]),
            .right_in (right_ent[gi]),
            .own_out  (ent[gi]),
            .key_lt   (lt[gi])
         );
      end
   endgenerate

   assign status.head   = ent[0];
   assign status.second = ent[1];
   assign status.full   = ent[QUEUE_DEPTH-1].valid;

   `TWPQ_ASSERT_IMPLY(a_head_fills_first, clock, reset, status.second.valid, status.head.valid)
   `TWPQ_ASSERT_IMPLY(a_head_sorted, clock, reset, status.second.valid,
      !key_less(status.second, status.head))
   `TWPQ_ASSERT_IMPLY(a_no_insert_full, clock, reset, cmd.insert, !status.full && !cmd.shift)
   `TWPQ_ASSERT_NEXT(a_insert_empty_fills, clock, reset, cmd.insert && !status.head.valid,
      status.head.valid)

endmodule

FILE: hw/rtl/timer_wakeup_priority_queue_unit.sv
// Top level of the timer wakeup priority queue.
//
// Requests arrive on req_valid/req_stall/req_data: mode 0 enqueues
// (handle_id, time_value), mode 1 ticks with the current time, mode 2
// peeks at the earliest entry. Results leave on rsp_valid/rsp_stall/rsp_data.
// A request is held in one input register, so a new request is taken while
// the previous result still waits in the output register.
// Entries live in a sorted chain of QUEUE_DEPTH cells; the head cell holds
// the earliest (wake time, handle). An enqueue inserts the entry in order, a
// release shifts the whole chain one cell toward the head.
// A request is registered in the input register and its result in the output
// register; a tick registers each further released entry in turn.
// req_stall is high while the input register holds a request, so a new
// request is taken only once the held one is done, and a tick is done only
// with the last entry that it releases.
// Reset empties the chain and drops any held request and result.
// While a result waits under rsp_stall the result register and the chain
// hold, and req_stall stays high once the input register is occupied.
`timescale 1ns / 1ps
module timer_wakeup_priority_queue_unit #(
   parameter int QUEUE_DEPTH = twpq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  twpq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output twpq_pkg::rsp_type rsp_data
);
   import twpq_pkg::*;

   logic       pend_valid_ff, pend_valid_in;
   req_type    pend_ff, pend_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;
   logic       out_free;
   logic       work;
   logic       head_due;
   logic       second_due;
   logic       done;
   cmd_type    cmd;
   entry_type  key;
   status_type status;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign work       = pend_valid_ff && out_free;
   assign head_due   = status.head.valid && (status.head.wake_time <= pend_ff.time_value);
   assign second_due = status.second.valid &&
                       (status.second.wake_time <= pend_ff.time_value);

   assign key.valid     = 1'b1;
   assign key.wake_time = pend_ff.time_value;
   assign key.handle    = pend_ff.handle_id;

   always_comb begin
      cmd    = '0;
      rsp_in = '0;
      done   = 1'b1;
      rsp_in.last_of_run = 1'b1;
      unique case (pend_ff.mode)
         MODE_ENQ: begin
            rsp_in.overflow = status.full;
            cmd.insert      = work && !status.full;
         end
         MODE_TICK: begin
            if (head_due) begin
               rsp_in.has_entry     = 1'b1;
               rsp_in.out_handle    = status.head.handle;
               rsp_in.out_wake_time = status.head.wake_time;
               rsp_in.last_of_run   = !second_due;
               done                 = !second_due;
               cmd.shift            = work;
            end
         end
         MODE_PEEK: begin
            if (status.head.valid) begin
               rsp_in.has_entry     = 1'b1;
               rsp_in.out_handle    = status.head.handle;
               rsp_in.out_wake_time = status.head.wake_time;
            end
         end
         default: begin
            rsp_in.last_of_run = 1'b1;
         end
      endcase
   end

   assign req_stall = pend_valid_ff;

   always_comb begin
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      priority if (!pend_valid_ff && req_valid) begin
         pend_in       = req_data;
         pend_valid_in = 1'b1;
      end else if (work && done) begin
         pend_valid_in = 1'b0;
      end else begin
         pend_valid_in = pend_valid_ff;
      end
   end

   assign rsp_valid_in = work || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      if (work) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   twpq_chain #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_chain (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .key_in (key),
      .status (status)
   );

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the timer wakeup priority queue unit.
`timescale 1ns / 1ps
module tb_top;
   import twpq_pkg::*;

   localparam int          QUEUE_DEPTH  = QUEUE_DEPTH_DEF;
   localparam logic [1:0]  MODE_NOP     = 2'd3;
   localparam logic [62:0] TIME_MAX     = '1;
   localparam int          RANDOM_ITEMS = 260;
   localparam int          LONG_HOLD    = 300;
   localparam int          DRAIN_LIMIT  = 100000;

   typedef struct packed {
      logic [TIME_W-1:0]   wake;
      logic [HANDLE_W-1:0] handle;
   } sleeper_type;

   typedef struct {
      req_type     req;
      int unsigned count;
      logic [62:0] step;
      bit          typed;
      rsp_type     want;
   } stim_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   sleeper_type  sleepers[$];
   rsp_type      step_rsp[$];
   rsp_type      expected_rsp_q[$];
   stim_row_type stim_rows[$];

   int unsigned tx_idle_pct;
   int unsigned rx_idle_pct;
   bit          long_hold_armed;
   int          error_count;
   int          sent_count;
   int          rsp_count;
   int          ovf_count;
   int          run_len;
   int          longest_run;
   int          stall_streak;
   int          longest_stall;

   timer_wakeup_priority_queue_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic rsp_type make_rsp(logic has, logic [HANDLE_W-1:0] h,
                                        logic [TIME_W-1:0] t, logic last, logic ovf);
      rsp_type r;
      r.has_entry     = has;
      r.out_handle    = h;
      r.out_wake_time = t;
      r.last_of_run   = last;
      r.overflow      = ovf;
      return r;
   endfunction

   function automatic stim_row_type stim_row(logic [1:0] m, logic [HANDLE_W-1:0] h,
                                             logic [TIME_W-1:0] t, int unsigned n,
                                             logic [62:0] step, bit typed, rsp_type want);
      stim_row_type row;
      row.req.mode       = m;
      row.req.handle_id  = h;
      row.req.time_value = t;
      row.count          = n;
      row.step           = step;
      row.typed          = typed;
      row.want           = want;
      return row;
   endfunction

   function automatic void add_row(input stim_row_type row);
      stim_rows.insert(stim_rows.size(), row);
   endfunction

   function automatic void add_step_rsp(input rsp_type r);
      step_rsp.insert(step_rsp.size(), r);
   endfunction

   function automatic void add_expected(input rsp_type r);
      expected_rsp_q.insert(expected_rsp_q.size(), r);
   endfunction

   function automatic int earliest_sleeper();
      int best;
      best = 0;
      for (int i = 1; i < sleepers.size(); i++) begin
         if (sleepers[i].wake < sleepers[best].wake ||
             (sleepers[i].wake == sleepers[best].wake &&
              sleepers[i].handle < sleepers[best].handle))
            best = i;
      end
      return best;
   endfunction

   function automatic void predict_step(input req_type r);
      int          best;
      sleeper_type s;
      step_rsp.delete();
      case (r.mode)
         MODE_ENQ: begin
            if (sleepers.size() >= QUEUE_DEPTH) begin
               add_step_rsp(make_rsp(1'b0, '0, '0, 1'b1, 1'b1));
            end else begin
               s.wake   = r.time_value;
               s.handle = r.handle_id;
               sleepers.insert(sleepers.size(), s);
               add_step_rsp(make_rsp(1'b0, '0, '0, 1'b1, 1'b0));
            end
         end
         MODE_TICK: begin
            while (sleepers.size() > 0) begin
               best = earliest_sleeper();
               if (sleepers[best].wake > r.time_value) break;
               add_step_rsp(make_rsp(1'b1, sleepers[best].handle,
                                     sleepers[best].wake, 1'b0, 1'b0));
               sleepers.delete(best);
            end
            if (step_rsp.size() == 0)
               add_step_rsp(make_rsp(1'b0, '0, '0, 1'b1, 1'b0));
            else
               step_rsp[step_rsp.size()-1].last_of_run = 1'b1;
         end
         MODE_PEEK: begin
            if (sleepers.size() == 0) begin
               add_step_rsp(make_rsp(1'b0, '0, '0, 1'b1, 1'b0));
            end else begin
               best = earliest_sleeper();
               add_step_rsp(make_rsp(1'b1, sleepers[best].handle,
                                     sleepers[best].wake, 1'b1, 1'b0));
            end
         end
         default: add_step_rsp(make_rsp(1'b0, '0, '0, 1'b1, 1'b0));
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
   endtask

   task automatic send_request(input req_type r, input bit typed, input rsp_type want);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_step(r);
      if (typed)
         add_expected(want);
      else
         foreach (step_rsp[i]) add_expected(step_rsp[i]);
      sent_count++;
   endtask

   // receiver: random stall, plus one long hold-off to back up the block
   initial begin : receiver
      int hold_count;
      bit hold_done;
      hold_count = 0;
      hold_done  = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_armed && !hold_done) begin
            hold_count++;
            rsp_stall <= 1'b1;
            if (hold_count >= LONG_HOLD) hold_done = 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rx_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_stall) begin
            stall_streak++;
            if (stall_streak > longest_stall) longest_stall = stall_streak;
         end else begin
            stall_streak = 0;
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            if (rsp_data.overflow === 1'b1) ovf_count++;
            if (rsp_data.has_entry === 1'b1) run_len++;
            if (rsp_data.last_of_run === 1'b1) begin
               if (run_len > longest_run) longest_run = run_len;
               run_len = 0;
            end
            if (expected_rsp_q.size() == 0) begin
               report_mismatch("unexpected response", 64'(rsp_data), 64'h0);
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_data.has_entry !== want.has_entry)
                  report_mismatch("has_entry", 64'(rsp_data.has_entry), 64'(want.has_entry));
               if (rsp_data.out_handle !== want.out_handle)
                  report_mismatch("out_handle", 64'(rsp_data.out_handle),
                                  64'(want.out_handle));
               if (rsp_data.out_wake_time !== want.out_wake_time)
                  report_mismatch("out_wake_time", 64'(rsp_data.out_wake_time),
                                  64'(want.out_wake_time));
               if (rsp_data.last_of_run !== want.last_of_run)
                  report_mismatch("last_of_run", 64'(rsp_data.last_of_run),
                                  64'(want.last_of_run));
               if (rsp_data.overflow !== want.overflow)
                  report_mismatch("overflow", 64'(rsp_data.overflow), 64'(want.overflow));
            end
         end
      end
   end

   initial begin
      #(20_000_000);
      $display("FAILURE");
      $finish;
   end

   initial begin : stimulus
      rsp_type      quiet;
      rsp_type      dropped;
      req_type      r;
      stim_row_type row;
      logic [62:0]  clock_now;
      logic [63:0]  rnd64;
      logic [31:0]  rnd32;
      int unsigned  sel;
      int           wait_cycles;

      clock           = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_data        = '0;
      rsp_stall       = 1'b0;
      long_hold_armed = 1'b0;
      tx_idle_pct     = 37;
      rx_idle_pct     = 83;
      error_count     = 0;
      sent_count      = 0;
      rsp_count       = 0;
      ovf_count       = 0;
      run_len         = 0;
      longest_run     = 0;
      stall_streak    = 0;
      longest_stall   = 0;

      quiet   = make_rsp(1'b0, '0, '0, 1'b1, 1'b0);
      dropped = make_rsp(1'b0, '0, '0, 1'b1, 1'b1);

      add_row(stim_row(MODE_PEEK, 16'h0000, 63'd0, 1, 63'd0, 1'b1, quiet));
      add_row(stim_row(MODE_TICK, 16'h0000, 63'd0, 1, 63'd0, 1'b1, quiet));
      add_row(stim_row(MODE_TICK, 16'hffff, TIME_MAX, 1, 63'd0, 1'b1, quiet));
      add_row(stim_row(MODE_NOP, 16'hffff, TIME_MAX, 1, 63'd0, 1'b1, quiet));
      add_row(stim_row(MODE_ENQ, 16'h0000, 63'd0, 1, 63'd0, 1'b1, quiet));
      add_row(stim_row(MODE_ENQ, 16'hffff, TIME_MAX, 1, 63'd0, 1'b1, quiet));
      add_row(stim_row(MODE_PEEK, 16'h1234, 63'd99, 1, 63'd0, 1'b1,
                       make_rsp(1'b1, 16'h0000, 63'd0, 1'b1, 1'b0)));
      add_row(stim_row(MODE_ENQ, 16'h0005, 63'd100, 1, 63'd0, 1'b1, quiet));
      add_row(stim_row(MODE_ENQ, 16'h0003, 63'd100, 1, 63'd0, 1'b1, quiet));
      add_row(stim_row(MODE_ENQ, 16'h0003, 63'd100, 1, 63'd0, 1'b1, quiet));
      add_row(stim_row(MODE_ENQ, 16'h0009, 63'd50, 1, 63'd0, 1'b1, quiet));
      add_row(stim_row(MODE_TICK, 16'hffff, 63'd0, 1, 63'd0, 1'b1,
                       make_rsp(1'b1, 16'h0000, 63'd0, 1'b1, 1'b0)));
      add_row(stim_row(MODE_TICK, 16'h0000, 63'd49, 1, 63'd0, 1'b1, quiet));
      add_row(stim_row(MODE_TICK, 16'h0000, 63'd100, 1, 63'd0, 1'b0, quiet));
      add_row(stim_row(MODE_PEEK, 16'h0000, 63'd0, 1, 63'd0, 1'b1,
                       make_rsp(1'b1, 16'hffff, TIME_MAX, 1'b1, 1'b0)));
      add_row(stim_row(MODE_NOP, 16'h1234, 63'd77, 1, 63'd0, 1'b1, quiet));
      add_row(stim_row(MODE_ENQ, 16'h8000, 63'h4000_0000_0000_0000, 63, 63'd7919,
                       1'b0, quiet));
      add_row(stim_row(MODE_ENQ, 16'h0001, 63'd1, 1, 63'd0, 1'b1, dropped));
      add_row(stim_row(MODE_NOP, 16'h0000, 63'd0, 1, 63'd0, 1'b1, quiet));
      add_row(stim_row(MODE_PEEK, 16'h0000, 63'd0, 1, 63'd0, 1'b0, quiet));
      add_row(stim_row(MODE_TICK, 16'h0000, TIME_MAX, 1, 63'd0, 1'b0, quiet));
      add_row(stim_row(MODE_TICK, 16'h0000, TIME_MAX, 1, 63'd0, 1'b1, quiet));
      add_row(stim_row(MODE_ENQ, 16'haaaa, 63'h2aaa_aaaa_aaaa_aaaa, 1, 63'd0, 1'b1,
                       quiet));
      add_row(stim_row(MODE_ENQ, 16'h5555, 63'h5555_5555_5555_5555, 1, 63'd0, 1'b1,
                       quiet));
      add_row(stim_row(MODE_TICK, 16'h0000, TIME_MAX, 1, 63'd0, 1'b0, quiet));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i]) begin
         row = stim_rows[i];
         for (int k = 0; k < row.count; k++) begin
            r = row.req;
            r.handle_id  = row.req.handle_id + 16'(k);
            r.time_value = row.req.time_value + row.step * 63'(k);
            send_request(r, row.typed, row.want);
         end
      end

      rnd32     = $urandom;
      clock_now = 63'(rnd32);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) begin
            tx_idle_pct = 83;
            rx_idle_pct = 37;
         end
         if (n == 2 * RANDOM_ITEMS / 3) begin
            tx_idle_pct     = 0;
            rx_idle_pct     = 0;
            long_hold_armed = 1'b1;
         end
         sel   = $urandom_range(99);
         rnd32 = $urandom;
         rnd64 = {$urandom, $urandom};
         r.handle_id  = ($urandom_range(3) == 0) ? 16'($urandom_range(7)) : rnd32[15:0];
         r.time_value = rnd64[62:0];
         if (sel < 45) begin
            r.mode = MODE_ENQ;
            case ($urandom_range(9))
               0:       r.time_value = rnd64[62:0];
               1:       r.time_value = ($urandom_range(1) == 0) ? 63'd0 : TIME_MAX;
               2, 3:    r.time_value = clock_now + 63'($urandom_range(3) * 10);
               default: r.time_value = clock_now + 63'($urandom_range(300));
            endcase
         end else if (sel < 72) begin
            r.mode    = MODE_TICK;
            clock_now = clock_now + 63'($urandom_range(150));
            case ($urandom_range(19))
               0:       r.time_value = TIME_MAX;
               1:       r.time_value = rnd64[62:0];
               2:       r.time_value = 63'd0;
               default: r.time_value = clock_now;
            endcase
         end else if (sel < 92) begin
            r.mode = MODE_PEEK;
         end else begin
            r.mode = MODE_NOP;
         end
         send_request(r, 1'b0, quiet);
      end
      req_valid <= 1'b0;

      wait_cycles = 0;
      while (expected_rsp_q.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (8) @(posedge clock);
      if (expected_rsp_q.size() != 0)
         report_mismatch("responses never delivered", 64'(expected_rsp_q.size()), 64'h0);

      $display("covered %0d requests in enqueue, tick, peek and no-op modes, %0d responses",
               sent_count, rsp_count);
      $display("overflow drops %0d, longest release run %0d, longest input stall %0d cycles",
               ovf_count, longest_run, longest_stall);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
